// ===== sv/css_pkg.sv =====
// Shared types and constants of the CPU slice scheduler.
package css_pkg;

   localparam int TIME_W   = 16;
   localparam int PRIO_W   = 8;
   localparam int PINDEX_W = 6;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_LOAD    = 2'd1,
      OP_STEP    = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_RUN        = 3'd0,
      ST_IDLE_SLICE = 3'd1,
      ST_ALL_DONE   = 3'd2,
      ST_LOADED     = 3'd3,
      ST_FULL       = 3'd4,
      ST_CLEARED    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MODE_FCFS = 2'd0,
      MODE_RR   = 2'd1,
      MODE_SJF  = 2'd2,
      MODE_PRIO = 2'd3
   } mode_type;

   localparam logic CSR_SCHED_MODE   = 1'b0;
   localparam logic CSR_TIME_QUANTUM = 1'b1;

   typedef struct packed {
      op_type              op;
      logic [TIME_W-1:0]   arrival_time;
      logic [TIME_W-1:0]   burst_time;
      logic [PRIO_W-1:0]   priority_level;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [PINDEX_W-1:0] proc_index;
      logic [TIME_W-1:0]   slice_start;
      logic [TIME_W-1:0]   slice_length;
      logic [TIME_W-1:0]   remaining_after;
      logic                completed;
      logic [TIME_W-1:0]   turnaround_time;
      logic [TIME_W-1:0]   waiting_time;
      logic [TIME_W-1:0]   response_time;
   } rsp_type;

   // One table entry as held in the stores.
   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] first_start;
   } entry_type;

   typedef struct packed {
      logic arrival;
      logic burst;
      logic remaining;
      logic prio;
      logic first_start;
   } wr_en_type;

   typedef struct packed {
      logic pending;
      logic hi_valid;
      logic lo_valid;
      logic best_valid;
   } scan_flags_type;

endpackage

// ===== sv/css_store.sv =====
// Entry table memories: one write port and one registered read port.
module css_store #(
   parameter int ENTRIES = 64
) (
   input  logic                          clock,
   input  css_pkg::wr_en_type            wr_en,
   input  logic [$clog2(ENTRIES)-1:0]    wr_addr,
   input  css_pkg::entry_type            wr_data,
   input  logic [$clog2(ENTRIES)-1:0]    rd_addr,
   output css_pkg::entry_type            rd_data
);

   logic [css_pkg::TIME_W-1:0] arrival_mem     [ENTRIES];
   logic [css_pkg::TIME_W-1:0] burst_mem       [ENTRIES];
   logic [css_pkg::TIME_W-1:0] remaining_mem   [ENTRIES];
   logic [css_pkg::PRIO_W-1:0] prio_mem        [ENTRIES];
   logic [css_pkg::TIME_W-1:0] first_start_mem [ENTRIES];

   css_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en.arrival) begin
         arrival_mem[wr_addr] <= wr_data.arrival;
      end
      if (wr_en.burst) begin
         burst_mem[wr_addr] <= wr_data.burst;
      end
      if (wr_en.remaining) begin
         remaining_mem[wr_addr] <= wr_data.remaining;
      end
      if (wr_en.prio) begin
         prio_mem[wr_addr] <= wr_data.prio;
      end
      if (wr_en.first_start) begin
         first_start_mem[wr_addr] <= wr_data.first_start;
      end
      rd_data_ff.arrival     <= arrival_mem[rd_addr];
      rd_data_ff.burst       <= burst_mem[rd_addr];
      rd_data_ff.remaining   <= remaining_mem[rd_addr];
      rd_data_ff.prio        <= prio_mem[rd_addr];
      rd_data_ff.first_start <= first_start_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/css_scan.sv =====
// Per-entry ready test and candidate tracking, one entry per cycle.
module css_scan #(
   parameter int ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          eval_valid,
   input  logic [$clog2(ENTRIES)-1:0]    eval_idx,
   input  css_pkg::entry_type            entry,
   input  logic [css_pkg::TIME_W-1:0]    cur_time,
   input  logic [$clog2(ENTRIES)-1:0]    scan_pos,
   input  logic                          use_burst_key,
   output css_pkg::scan_flags_type       flags,
   output logic [$clog2(ENTRIES)-1:0]    hi_idx,
   output logic [$clog2(ENTRIES)-1:0]    lo_idx,
   output logic [$clog2(ENTRIES)-1:0]    best_idx
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int TW    = css_pkg::TIME_W;

   css_pkg::scan_flags_type flags_ff, flags_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] best_ff, best_in;
   logic [TW-1:0]    best_key_ff, best_key_in;
   logic             ready;
   logic [TW-1:0]    key;

   always_comb begin
      ready = (entry.remaining != '0) && (entry.arrival <= cur_time);
      key   = use_burst_key ? entry.burst
                            : {{(TW - css_pkg::PRIO_W){1'b0}}, entry.prio};
      flags_in    = flags_ff;
      hi_in       = hi_ff;
      lo_in       = lo_ff;
      best_in     = best_ff;
      best_key_in = best_key_ff;
      if (start) begin
         flags_in = '0;
      end else if (eval_valid) begin
         if (entry.remaining != '0) begin
            flags_in.pending = 1'b1;
         end
         if (ready) begin
            if (!flags_ff.lo_valid) begin
               flags_in.lo_valid = 1'b1;
               lo_in             = eval_idx;
            end
            if (!flags_ff.hi_valid && (eval_idx >= scan_pos)) begin
               flags_in.hi_valid = 1'b1;
               hi_in             = eval_idx;
            end
            // strict compare keeps the lowest slot on a tie
            if (!flags_ff.best_valid || (key < best_key_ff)) begin
               flags_in.best_valid = 1'b1;
               best_in             = eval_idx;
               best_key_in         = key;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
   end

   assign flags    = flags_ff;
   assign hi_idx   = hi_ff;
   assign lo_idx   = lo_ff;
   assign best_idx = best_ff;

endmodule

// ===== sv/cpu_slice_scheduler_unit.sv =====
// Top level of the CPU slice scheduler: sequencer, slice arithmetic and run state.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   css_pkg::req_type
//   rsp       out        rsp_valid/rsp_stall   css_pkg::rsp_type
//   csr       in         csr_we                csr_index, csr_wdata
//
// Clear and load answer in the next cycle. A step sweeps the table through the single
// read port, one entry a cycle, then passes a drain and a decide state, then the slice
// arithmetic states (length, time, stats, finish) when an entry runs. Restart rewrites every
// remaining time from its burst time. Reset is synchronous and needs no clearing pass.
// req_stall stays high while an item is at work or a result is held on rsp.
module cpu_slice_scheduler_unit #(
   parameter int ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  css_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output css_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [css_pkg::TIME_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int TW    = css_pkg::TIME_W;
   localparam int PW    = css_pkg::PINDEX_W;

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_SWEEP     = 10'b00_0000_0010,
      S_DRAIN     = 10'b00_0000_0100,
      S_DECIDE    = 10'b00_0000_1000,
      S_LEN       = 10'b00_0001_0000,
      S_TIME      = 10'b00_0010_0000,
      S_STATS     = 10'b00_0100_0000,
      S_FINISH    = 10'b00_1000_0000,
      S_RST_SWEEP = 10'b01_0000_0000,
      S_RST_DRAIN = 10'b10_0000_0000
   } fsm_type;

   fsm_type               state_ff, state_in;
   css_pkg::mode_type     mode_ff, mode_in;
   logic [TW-1:0]         quantum_ff, quantum_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TW-1:0]         time_ff, time_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic                  ran_ff, ran_in;
   logic [ENTRIES-1:0]    started_ff, started_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  eval_valid_ff, eval_valid_in;
   logic                  rst_wr_ff, rst_wr_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]      eval_idx_ff, eval_idx_in;
   logic [IDX_W-1:0]      chosen_ff, chosen_in;
   logic [TW-1:0]         len_ff, len_in;
   logic [TW-1:0]         arr_ff, arr_in;
   logic [TW-1:0]         bur_ff, bur_in;
   logic [TW-1:0]         rem_ff, rem_in;
   logic [TW-1:0]         fs_ff, fs_in;
   logic [TW-1:0]         new_time_ff, new_time_in;
   logic [TW-1:0]         new_rem_ff, new_rem_in;
   logic [TW-1:0]         tat_ff, tat_in;
   logic [TW-1:0]         resp_time_ff, resp_time_in;
   css_pkg::rsp_type      rsp_ff, rsp_in;

   css_pkg::wr_en_type      wr_en;
   logic [IDX_W-1:0]        wr_addr;
   css_pkg::entry_type      wr_data;
   logic [IDX_W-1:0]        rd_addr;
   css_pkg::entry_type      rd_data;
   logic                    scan_start;
   css_pkg::scan_flags_type flags;
   logic [IDX_W-1:0]        hi_idx;
   logic [IDX_W-1:0]        lo_idx;
   logic [IDX_W-1:0]        best_idx;

   logic                  accept;
   logic                  scan_mode;
   logic                  sel_valid;
   logic [IDX_W-1:0]      sel_idx;
   logic [CNT_W-1:0]      next_pos;
   logic                  last_issue;
   logic                  clear_run;
   logic [TW-1:0]         quantum_eff;
   logic [TW:0]           time_sum;
   logic                  done;
   logic [IDX_W+PW-1:0]   chosen_ext;
   logic [IDX_W+PW-1:0]   load_ext;

   css_store #(.ENTRIES(ENTRIES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   css_scan #(.ENTRIES(ENTRIES)) u_scan (
      .clock         (clock),
      .reset         (reset),
      .start         (scan_start),
      .eval_valid    (eval_valid_ff),
      .eval_idx      (eval_idx_ff),
      .entry         (rd_data),
      .cur_time      (time_ff),
      .scan_pos      (scan_ff),
      .use_burst_key (mode_ff == css_pkg::MODE_SJF),
      .flags         (flags),
      .hi_idx        (hi_idx),
      .lo_idx        (lo_idx),
      .best_idx      (best_idx)
   );

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign chosen_ext = {{PW{1'b0}}, chosen_ff};
   assign load_ext   = {{PW{1'b0}}, count_ff[IDX_W-1:0]};

   always_comb begin
      scan_mode = (mode_ff == css_pkg::MODE_FCFS) || (mode_ff == css_pkg::MODE_RR);
      if (scan_mode) begin
         // resume from the scan position, wrap to slot 0 only after a pass that ran
         sel_valid = flags.hi_valid || (ran_ff && flags.lo_valid);
         sel_idx   = flags.hi_valid ? hi_idx : lo_idx;
      end else begin
         sel_valid = flags.best_valid;
         sel_idx   = best_idx;
      end
      next_pos    = CNT_W'(sel_idx) + CNT_W'(1);
      last_issue  = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));
      quantum_eff = (quantum_ff == '0) ? TW'(1) : quantum_ff;
      time_sum    = {1'b0, time_ff} + {1'b0, len_ff};
      done        = (new_rem_ff == '0);
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      quantum_in    = quantum_ff;
      count_in      = count_ff;
      time_in       = time_ff;
      scan_in       = scan_ff;
      ran_in        = ran_ff;
      started_in    = started_ff;
      idx_in        = idx_ff;
      eval_valid_in = 1'b0;
      rst_wr_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      eval_idx_in   = idx_ff;
      chosen_in     = chosen_ff;
      len_in        = len_ff;
      arr_in        = arr_ff;
      bur_in        = bur_ff;
      rem_in        = rem_ff;
      fs_in         = fs_ff;
      new_time_in   = new_time_ff;
      new_rem_in    = new_rem_ff;
      tat_in        = tat_ff;
      resp_time_in  = resp_time_ff;
      rsp_in        = rsp_ff;
      wr_en         = '0;
      wr_addr       = chosen_ff;
      wr_data       = '0;
      rd_addr       = chosen_ff;
      scan_start    = 1'b0;
      clear_run     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  css_pkg::OP_CLEAR: begin
                     count_in     = '0;
                     clear_run    = 1'b1;
                     rsp_in       = '0;
                     rsp_in.status = css_pkg::ST_CLEARED;
                     rsp_valid_in = 1'b1;
                  end
                  css_pkg::OP_LOAD: begin
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_W'(ENTRIES)) begin
                        rsp_in.status = css_pkg::ST_FULL;
                     end else begin
                        wr_en.arrival     = 1'b1;
                        wr_en.burst       = 1'b1;
                        wr_en.remaining   = 1'b1;
                        wr_en.prio        = 1'b1;
                        wr_addr           = count_ff[IDX_W-1:0];
                        wr_data.arrival   = req_data.arrival_time;
                        wr_data.burst     = req_data.burst_time;
                        wr_data.remaining = req_data.burst_time;
                        wr_data.prio      = req_data.priority_level;
                        started_in[count_ff[IDX_W-1:0]] = 1'b0;
                        count_in          = count_ff + CNT_W'(1);
                        rsp_in.status     = css_pkg::ST_LOADED;
                        rsp_in.proc_index = load_ext[PW-1:0];
                     end
                  end
                  css_pkg::OP_STEP: begin
                     if (count_ff == '0) begin
                        rsp_in        = '0;
                        rsp_in.status = css_pkg::ST_ALL_DONE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        idx_in     = '0;
                        scan_start = 1'b1;
                        state_in   = S_SWEEP;
                     end
                  end
                  css_pkg::OP_RESTART: begin
                     if (count_ff == '0) begin
                        clear_run     = 1'b1;
                        rsp_in        = '0;
                        rsp_in.status = css_pkg::ST_CLEARED;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = S_RST_SWEEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SWEEP: begin
            rd_addr       = idx_ff;
            eval_valid_in = 1'b1;
            if (last_issue) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            if (!flags.pending) begin
               rsp_in        = '0;
               rsp_in.status = css_pkg::ST_ALL_DONE;
               rsp_valid_in  = 1'b1;
            end else if (!sel_valid) begin
               if (scan_mode) begin
                  scan_in = '0;
                  ran_in  = 1'b0;
               end
               rsp_in              = '0;
               rsp_in.status       = css_pkg::ST_IDLE_SLICE;
               rsp_in.slice_start  = time_ff;
               rsp_in.slice_length = TW'(1);
               rsp_valid_in        = 1'b1;
               if (time_ff != '1) begin
                  time_in = time_ff + TW'(1);
               end
            end else begin
               chosen_in = sel_idx;
               rd_addr   = sel_idx;
               state_in  = S_LEN;
               if (scan_mode) begin
                  if (next_pos >= count_ff) begin
                     scan_in = '0;
                     ran_in  = 1'b0;
                  end else begin
                     scan_in = next_pos[IDX_W-1:0];
                     ran_in  = 1'b1;
                  end
               end
            end
         end
         S_LEN: begin
            arr_in = rd_data.arrival;
            bur_in = rd_data.burst;
            rem_in = rd_data.remaining;
            fs_in  = started_ff[chosen_ff] ? rd_data.first_start : time_ff;
            case (mode_ff)
               css_pkg::MODE_FCFS: len_in = rd_data.remaining;
               css_pkg::MODE_RR: begin
                  len_in = (quantum_eff < rd_data.remaining) ? quantum_eff
                                                             : rd_data.remaining;
               end
               default: len_in = TW'(1);
            endcase
            state_in = S_TIME;
         end
         S_TIME: begin
            // saturate the clock at its top value
            new_time_in = time_sum[TW] ? '1 : time_sum[TW-1:0];
            new_rem_in  = rem_ff - len_ff;
            state_in    = S_STATS;
         end
         S_STATS: begin
            tat_in       = new_time_ff - arr_ff;
            resp_time_in = fs_ff - arr_ff;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            wr_en.remaining        = 1'b1;
            wr_en.first_start      = 1'b1;
            wr_data.remaining      = new_rem_ff;
            wr_data.first_start    = fs_ff;
            started_in[chosen_ff]  = 1'b1;
            time_in                = new_time_ff;
            rsp_in                 = '0;
            rsp_in.status          = css_pkg::ST_RUN;
            rsp_in.proc_index      = chosen_ext[PW-1:0];
            rsp_in.slice_start     = time_ff;
            rsp_in.slice_length    = len_ff;
            rsp_in.remaining_after = new_rem_ff;
            rsp_in.completed       = done;
            if (done) begin
               rsp_in.turnaround_time = tat_ff;
               rsp_in.waiting_time    = (tat_ff > bur_ff) ? (tat_ff - bur_ff) : '0;
               rsp_in.response_time   = resp_time_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_RST_SWEEP: begin
            rd_addr   = idx_ff;
            rst_wr_in = 1'b1;
            if (rst_wr_ff) begin
               wr_en.remaining   = 1'b1;
               wr_addr           = eval_idx_ff;
               wr_data.remaining = rd_data.burst;
            end
            if (last_issue) begin
               state_in = S_RST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_RST_DRAIN: begin
            if (rst_wr_ff) begin
               wr_en.remaining   = 1'b1;
               wr_addr           = eval_idx_ff;
               wr_data.remaining = rd_data.burst;
            end
            clear_run     = 1'b1;
            rsp_in        = '0;
            rsp_in.status = css_pkg::ST_CLEARED;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (clear_run) begin
         time_in    = '0;
         scan_in    = '0;
         ran_in     = 1'b0;
         started_in = '0;
      end

      if (csr_we) begin
         case (csr_index)
            css_pkg::CSR_SCHED_MODE:   mode_in    = css_pkg::mode_type'(csr_wdata[1:0]);
            css_pkg::CSR_TIME_QUANTUM: quantum_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= css_pkg::MODE_FCFS;
         quantum_ff    <= TW'(1);
         count_ff      <= '0;
         time_ff       <= '0;
         scan_ff       <= '0;
         ran_ff        <= 1'b0;
         started_ff    <= '0;
         idx_ff        <= '0;
         eval_valid_ff <= 1'b0;
         rst_wr_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         quantum_ff    <= quantum_in;
         count_ff      <= count_in;
         time_ff       <= time_in;
         scan_ff       <= scan_in;
         ran_ff        <= ran_in;
         started_ff    <= started_in;
         idx_ff        <= idx_in;
         eval_valid_ff <= eval_valid_in;
         rst_wr_ff     <= rst_wr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff  <= eval_idx_in;
      chosen_ff    <= chosen_in;
      len_ff       <= len_in;
      arr_ff       <= arr_in;
      bur_ff       <= bur_in;
      rem_ff       <= rem_in;
      fs_ff        <= fs_in;
      new_time_ff  <= new_time_in;
      new_rem_ff   <= new_rem_in;
      tat_ff       <= tat_in;
      resp_time_ff <= resp_time_in;
      rsp_ff       <= rsp_in;
   end

endmodule

// ===== sv/css_checker.sv =====
// Port-level assertions for the CPU slice scheduler, bound to the top level.
module css_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input css_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input css_pkg::rsp_type rsp_data
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // no new item while a result waits on a stalled output
   a_req_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("req taken while rsp is stalled");

   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.op == css_pkg::OP_CLEAR)
      |=> rsp_valid && (rsp_data.status == css_pkg::ST_CLEARED))
      else $error("clear did not answer in the next cycle");

   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.op == css_pkg::OP_LOAD)
      |=> rsp_valid && ((rsp_data.status == css_pkg::ST_LOADED) ||
                        (rsp_data.status == css_pkg::ST_FULL)))
      else $error("load did not answer in the next cycle");

   a_idle_slice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == css_pkg::ST_IDLE_SLICE)
      |-> (rsp_data.slice_length == 16'd1) && !rsp_data.completed)
      else $error("idle slice beat malformed");

endmodule

bind cpu_slice_scheduler_unit css_checker u_css_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
